@@ src/pdrs_pkg.sv @@
// Shared types and constants for the parity directed record sort block.
package pdrs_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 32;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} record_t;

endpackage

@@ src/parity_directed_record_sort_top.sv @@
// Top level of the parity directed record sort block: record store, exchange sort sequencer and output.
//
// Each item is one record, taken while busy is low and written into the record store. An item
// with final_req set closes the set. The block then stays busy and sorts the stored records in
// place with an exchange sort through the one-read, one-write record memory. The sort uses one
// compare per cycle while it scans a row. The results then follow back to back, each marked by valid
// for one cycle, and busy falls in the cycle of the last one. The receiver cannot stall them. An odd
// record count sorts descending and an even count sorts ascending. Records that arrive while the store
// holds MAX_RECORDS entries are dropped, and overflow is then set on every result of that set.
module parity_directed_record_sort_top #(
	parameter int MAX_RECORDS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [pdrs_pkg::KEY_W-1:0] key,
	input  logic [pdrs_pkg::TAG_W-1:0] tag,
	input  logic final_req,
	output logic valid,
	output logic signed [pdrs_pkg::KEY_W-1:0] sorted_key,
	output logic [pdrs_pkg::TAG_W-1:0] sorted_tag,
	output logic end_of_set,
	output logic overflow
);

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD_A,
		S_SCAN,
		S_WB,
		S_EMIT
	} state_t;

	state_t state_q;

	pdrs_pkg::record_t mem [MAX_RECORDS];
	pdrs_pkg::record_t rd_q;
	pdrs_pkg::record_t cur_q;
	pdrs_pkg::record_t wd;
	pdrs_pkg::record_t out_q;

	logic [CW-1:0] fill_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] a_q;
	logic [CW-1:0] b_q;
	logic [CW-1:0] emit_q;
	logic [AW-1:0] cmp_q;
	logic [CW-1:0] a_next;
	logic [CW-1:0] emit_next;
	logic dropped_q;
	logic valid_q;
	logic end_q;
	logic ovf_q;
	logic we;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic exch;
	logic has_room;
	logic last_emit;

	assign a_next = a_q + CW'(1);
	assign emit_next = emit_q + CW'(1);
	assign has_room = (fill_q < MAX_CNT);
	assign last_emit = (emit_next == n_q);
	assign exch = n_q[0] ? (cur_q.key < rd_q.key) : (cur_q.key > rd_q.key);

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = cur_q;
		ra = '0;
		case (state_q)
			S_IDLE: begin
				if (start && has_room) begin
					we = 1'b1;
					wa = fill_q[AW-1:0];
				end
				wd.key = key;
				wd.tag = tag;
			end
			S_FETCH: begin
				ra = a_q[AW-1:0];
			end
			S_LOAD_A: begin
				if (a_next < n_q) begin
					ra = a_next[AW-1:0];
				end
			end
			S_SCAN: begin
				if (b_q < n_q) begin
					ra = b_q[AW-1:0];
				end
				we = exch;
				wa = cmp_q;
			end
			S_WB: begin
				we = 1'b1;
				wa = a_q[AW-1:0];
				ra = a_next[AW-1:0];
			end
			S_EMIT: begin
				if (!last_emit) begin
					ra = emit_next[AW-1:0];
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD_A) begin
			cur_q <= rd_q;
		end else if (state_q == S_SCAN && exch) begin
			cur_q <= rd_q;
		end
		if (state_q == S_EMIT) begin
			out_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			n_q <= '0;
			a_q <= '0;
			b_q <= '0;
			emit_q <= '0;
			cmp_q <= '0;
			dropped_q <= 1'b0;
			valid_q <= 1'b0;
			end_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (has_room) begin
							fill_q <= fill_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (final_req) begin
							n_q <= has_room ? fill_q + CW'(1) : fill_q;
							a_q <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD_A;
				end
				S_LOAD_A: begin
					if (a_next < n_q) begin
						cmp_q <= a_next[AW-1:0];
						b_q <= a_next + CW'(1);
						state_q <= S_SCAN;
					end else begin
						emit_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (b_q < n_q) begin
						cmp_q <= b_q[AW-1:0];
						b_q <= b_q + CW'(1);
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					a_q <= a_next;
					state_q <= S_LOAD_A;
				end
				S_EMIT: begin
					valid_q <= 1'b1;
					end_q <= last_emit;
					ovf_q <= dropped_q;
					if (last_emit) begin
						fill_q <= '0;
						dropped_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						emit_q <= emit_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign valid = valid_q;
	assign sorted_key = out_q.key;
	assign sorted_tag = out_q.tag;
	assign end_of_set = end_q;
	assign overflow = ovf_q;

endmodule

@@ test/tb_parity_directed_record_sort_top.sv @@
// Self-checking testbench for the parity directed record sort block, with its own sort predictor.
module tb_parity_directed_record_sort_top;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int N_DIRECTED = 22;
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		pdrs_pkg::record_t rec;
		logic eos;
		logic ovf;
	} sorted_rec_t;

	typedef struct packed {
		logic [pdrs_pkg::KEY_W-1:0] key;
		logic [pdrs_pkg::TAG_W-1:0] tag;
		logic fin;
		logic typed;
		logic [pdrs_pkg::KEY_W-1:0] exp_key;
		logic [pdrs_pkg::TAG_W-1:0] exp_tag;
		logic exp_eos;
		logic exp_ovf;
	} dir_row_t;

	// Single-record sets carry their expected result; the other rows go through the predictor.
	localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
		'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'h8000_0000, 32'h5A5A_5A5A, 1'b1, 1'b1, 32'h8000_0000, 32'h5A5A_5A5A, 1'b1, 1'b0},
		'{32'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h8000_0000, 32'h0000_0002, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'hFFFF_FFFF, 32'h0000_0011, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0005, 32'h0000_0012, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h8000_0000, 32'h0000_0013, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 32'h0000_000A, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0007, 32'h0000_000B, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'hFFFF_FFF0, 32'h0000_0021, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'hFFFF_FFF0, 32'h0000_0022, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'hFFFF_FFF0, 32'h0000_0023, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0001, 32'h0000_0031, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'hFFFF_FFFF, 32'h0000_0032, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h7FFF_FFFF, 32'h0000_0033, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0000, 32'h0000_0034, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0001, 32'h0000_0041, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0002, 32'h0000_0042, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0003, 32'h0000_0043, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0004, 32'h0000_0044, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0},
		'{32'h0000_0005, 32'h0000_0045, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [pdrs_pkg::KEY_W-1:0] key;
	logic [pdrs_pkg::TAG_W-1:0] tag;
	logic final_req;
	logic valid;
	logic signed [pdrs_pkg::KEY_W-1:0] sorted_key;
	logic [pdrs_pkg::TAG_W-1:0] sorted_tag;
	logic end_of_set;
	logic overflow;

	pdrs_pkg::record_t set_store [DEPTH];
	int fill_cnt = 0;
	logic dropped = 1'b0;
	sorted_rec_t pending_sorted [$];
	int mismatches = 0;
	int cycles = 0;
	int sender_idle_pct = 19;

	parity_directed_record_sort_top #(
		.MAX_RECORDS(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.key(key),
		.tag(tag),
		.final_req(final_req),
		.valid(valid),
		.sorted_key(sorted_key),
		.sorted_tag(sorted_tag),
		.end_of_set(end_of_set),
		.overflow(overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stores one accepted record and, on the closing item, sorts the set and queues its results.
	task automatic take_record(input logic [pdrs_pkg::KEY_W-1:0] k,
			input logic [pdrs_pkg::TAG_W-1:0] t,
			input logic fin, input logic typed, input sorted_rec_t typed_exp);
		pdrs_pkg::record_t swap_rec;
		logic descending;
		logic exch;
		sorted_rec_t res;
		int i;
		int j;
		if (fill_cnt < DEPTH) begin
			set_store[fill_cnt] = '{key: k, tag: t};
			fill_cnt++;
		end else begin
			dropped = 1'b1;
		end
		if (fin) begin
			descending = fill_cnt[0];
			for (i = 0; i < fill_cnt; i++) begin
				for (j = i; j < fill_cnt; j++) begin
					if (descending)
						exch = $signed(set_store[i].key) < $signed(set_store[j].key);
					else
						exch = $signed(set_store[i].key) > $signed(set_store[j].key);
					if (exch) begin
						swap_rec = set_store[i];
						set_store[i] = set_store[j];
						set_store[j] = swap_rec;
					end
				end
			end
			if (typed) begin
				pending_sorted.push_back(typed_exp);
			end else begin
				for (i = 0; i < fill_cnt; i++) begin
					res.rec = set_store[i];
					res.eos = (i == fill_cnt - 1);
					res.ovf = dropped;
					pending_sorted.push_back(res);
				end
			end
			fill_cnt = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic send_record(input logic [pdrs_pkg::KEY_W-1:0] k,
			input logic [pdrs_pkg::TAG_W-1:0] t,
			input logic fin, input logic typed, input sorted_rec_t typed_exp);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		key <= k;
		tag <= t;
		final_req <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		take_record(k, t, fin, typed, typed_exp);
	endtask

	always @(posedge clk) begin
		sorted_rec_t want;
		if (arst_n && valid) begin
			if (pending_sorted.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected result: key %h tag %h end %b ovf %b",
						sorted_key, sorted_tag, end_of_set, overflow);
				mismatches++;
			end else begin
				want = pending_sorted.pop_front();
				if (sorted_key !== want.rec.key || sorted_tag !== want.rec.tag ||
						end_of_set !== want.eos || overflow !== want.ovf) begin
					if (mismatches < 10)
						$display("Mismatch: expected key %h tag %h end %b ovf %b,",
							want.rec.key, want.rec.tag, want.eos, want.ovf,
							" got key %h tag %h end %b ovf %b",
							sorted_key, sorted_tag, end_of_set, overflow);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		sorted_rec_t typed_exp;
		logic [pdrs_pkg::KEY_W-1:0] k;
		int i;
		int phase;
		int phase_items;
		int set_len;
		int n;
		arst_n <= 1'b0;
		start <= 1'b0;
		key <= '0;
		tag <= '0;
		final_req <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			typed_exp.rec = '{key: DIR_ROWS[i].exp_key, tag: DIR_ROWS[i].exp_tag};
			typed_exp.eos = DIR_ROWS[i].exp_eos;
			typed_exp.ovf = DIR_ROWS[i].exp_ovf;
			send_record(DIR_ROWS[i].key, DIR_ROWS[i].tag, DIR_ROWS[i].fin, DIR_ROWS[i].typed,
				typed_exp);
		end

		// Each phase opens with a full or overflowing set, then mostly small sets.
		for (phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 77 : 0;
			phase_items = 0;
			set_len = 64 + phase;
			while (phase_items < ITEMS_PER_PHASE) begin
				for (n = 0; n < set_len; n++) begin
					case ($urandom_range(3))
						0: k = $urandom_range(6) - 3;
						1: begin
							case ($urandom_range(3))
								0: k = 32'h8000_0000;
								1: k = 32'h7FFF_FFFF;
								2: k = '0;
								default: k = '1;
							endcase
						end
						default: k = $urandom;
					endcase
					send_record(k, $urandom, n == set_len - 1, 1'b0, '0);
				end
				phase_items += set_len;
				if ($urandom_range(24) == 0)
					set_len = $urandom_range(60, 68);
				else
					set_len = $urandom_range(1, 10);
			end
		end

		start <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_sorted.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
